[rtl/core/assert_macros.svh]
// Assertion macros used by the easing curve unit top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ECU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ECU_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ECU_ASSERT(label, prop, msg)
`define ECU_NEVER(label, expr, msg)
`endif
`endif

[rtl/core/ecu_pkg.sv]
// Types, constants, curve tables and fixed-point helpers for the easing curve unit.
package ecu_pkg;

    localparam int FRAC_BITS        = 16;
    localparam int SINE_TABLE_DEPTH = 256;
    localparam int EXP_TABLE_DEPTH  = 256;

    localparam int IB    = 28;
    localparam int QB    = IB - 2;
    localparam int SHIFT = IB - FRAC_BITS;

    localparam int OP_W   = 5;
    localparam int PROG_W = 17;
    localparam int OUT_W  = 18;
    localparam int VAL_W  = 36;
    localparam int MAG_W  = 32;
    localparam int ROM_W  = IB + 1;
    localparam int NSH_W  = 4;
    localparam int EXP_ARG_W = IB + NSH_W;
    localparam int SIDX_W = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int EIDX_W = $clog2(EXP_TABLE_DEPTH + 1);

    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic signed [OUT_W-1:0] out_t;
    typedef logic [ROM_W-1:0]        rom_word_t;
    typedef logic [IB-1:0]           phase_t;
    typedef logic [EXP_ARG_W-1:0]    exp_arg_t;

    localparam val_t IONE      = val_t'(64'sd1 <<< IB);
    localparam val_t HALF      = IONE >>> 1;
    localparam val_t BACK_S    = val_t'(64'sd456764403);
    localparam val_t BACK_S1   = val_t'(64'sd725199859);
    localparam val_t BOUNCE_K  = val_t'(64'sd2030043136);
    localparam val_t BOUNCE_C1 = val_t'(64'sd146419340);
    localparam val_t BOUNCE_C2 = val_t'(64'sd219629009);
    localparam val_t BOUNCE_C3 = val_t'(64'sd256233844);
    localparam val_t K_0750    = val_t'(64'sd201326592);
    localparam val_t K_0938    = val_t'(64'sd251658240);
    localparam val_t K_0984    = val_t'(64'sd264241152);
    localparam val_t EL_IN_OFS = val_t'(64'sd2885681152);
    localparam val_t OUT_MAX_V = val_t'(64'sd131071);
    localparam val_t OUT_MIN_V = val_t'(-64'sd131072);

    localparam longint unsigned PI_HALF_Q = 64'd421657428;
    localparam longint unsigned LN2_Q     = 64'd186065280;

    // floor(N/3) with N = 2^SHIFT * M: DIV3_Q*M + floor(DIV3_R*M/3)
    localparam longint unsigned DIV3_Q    = (64'd1 << SHIFT) / 3;
    localparam longint unsigned DIV3_R    = (64'd1 << SHIFT) % 3;
    localparam longint unsigned RECIP3    = 64'd715827883;
    localparam int              RECIP3_SH = 31;

    typedef enum logic [OP_W-1:0] {
        OP_LINEAR,
        OP_QUAD_IN,
        OP_QUAD_OUT,
        OP_QUAD_INOUT,
        OP_CUBIC_IN,
        OP_CUBIC_OUT,
        OP_CUBIC_INOUT,
        OP_SINE_IN,
        OP_SINE_OUT,
        OP_SINE_INOUT,
        OP_EXPO_IN,
        OP_EXPO_OUT,
        OP_EXPO_INOUT,
        OP_ELASTIC_IN,
        OP_ELASTIC_OUT,
        OP_BOUNCE_OUT,
        OP_BOUNCE_IN,
        OP_BACK_IN,
        OP_BACK_OUT
    } op_t;

    typedef struct packed {
        op_t  op;
        val_t t;
    } s1_t;

    typedef struct packed {
        op_t      op;
        val_t     t;
        logic     lo;
        val_t     x1;
        val_t     y1;
        val_t     z;
        val_t     y2;
        val_t     kb;
        phase_t   phase;
        exp_arg_t exp_arg;
    } s2_t;

    typedef struct packed {
        op_t             op;
        val_t            t;
        logic            lo;
        val_t            kb;
        val_t            m1;
        val_t            y2;
        rom_word_t       s_a;
        rom_word_t       s_d;
        logic [QB-1:0]   s_fr;
        logic            s_neg;
        rom_word_t       e_a;
        rom_word_t       e_d;
        logic [IB-1:0]   e_fr;
        logic [NSH_W-1:0] e_n;
    } s3_t;

    typedef struct packed {
        op_t  op;
        val_t t;
        logic lo;
        val_t kb;
        val_t m1;
        val_t m2;
        val_t sv;
        val_t ev;
    } s4_t;

    typedef rom_word_t sine_rom_t [SINE_TABLE_DEPTH+1];
    typedef rom_word_t exp_rom_t  [EXP_TABLE_DEPTH+1];

    function automatic longint unsigned umul_q(longint unsigned a, longint unsigned b);
        return (a * b + (64'd1 << (IB - 1))) >> IB;
    endfunction

    // shift-subtract quotient, only evaluated while the tables are built
    function automatic longint unsigned udiv_c(longint unsigned n, longint unsigned d);
        longint unsigned q;
        longint unsigned rem;
        q   = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[62:0], n[i]};
            if (rem >= d)
            begin
                rem  = rem - d;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // sin(i*pi/(2*depth)) by odd power series
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t       rom;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++)
        begin
            x    = (longint'(i) * PI_HALF_Q + SINE_TABLE_DEPTH / 2) / SINE_TABLE_DEPTH;
            x2   = umul_q(x, x);
            term = x;
            sum  = longint'(x);
            for (int k = 1; k <= 7; k++)
            begin
                term = udiv_c(umul_q(term, x2), 64'((2 * k) * (2 * k + 1)));
                if (k % 2 == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            if (sum > longint'(IONE))
                sum = longint'(IONE);
            rom[i] = rom_word_t'(sum);
        end
        return rom;
    endfunction

    // 2^-(j/depth) over one octave by exponential series
    function automatic exp_rom_t build_exp_rom();
        exp_rom_t        rom;
        longint unsigned f;
        longint unsigned z;
        longint unsigned term;
        longint          sum;
        for (int j = 0; j <= EXP_TABLE_DEPTH; j++)
        begin
            f    = (longint'(j) << IB) / EXP_TABLE_DEPTH;
            z    = umul_q(f, LN2_Q);
            term = longint'(IONE);
            sum  = longint'(IONE);
            for (int k = 1; k <= 12; k++)
            begin
                term = udiv_c(umul_q(term, z), 64'(k));
                if (k % 2 == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            rom[j] = rom_word_t'(sum);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();
    localparam exp_rom_t  EXP_ROM  = build_exp_rom();

    // sign-magnitude product, magnitude rounded half up
    function automatic val_t smul(val_t a, val_t b);
        val_t                   na;
        val_t                   nb;
        logic [MAG_W-1:0]       ma;
        logic [MAG_W-1:0]       mb;
        logic [2*MAG_W-1:0]     p;
        logic [VAL_W-1:0]       r;
        na = a[VAL_W-1] ? -a : a;
        nb = b[VAL_W-1] ? -b : b;
        ma = na[MAG_W-1:0];
        mb = nb[MAG_W-1:0];
        p  = (2*MAG_W)'(ma) * (2*MAG_W)'(mb);
        p  = p + ((2*MAG_W)'(1) << (IB - 1));
        r  = VAL_W'(p >> IB);
        return (a[VAL_W-1] ^ b[VAL_W-1]) ? -val_t'(r) : val_t'(r);
    endfunction

    function automatic out_t round_out(val_t v);
        logic [VAL_W-1:0] m;
        val_t             nv;
        val_t             r;
        nv = v[VAL_W-1] ? -v : v;
        m  = VAL_W'(nv);
        m  = (m + (VAL_W'(1) << (SHIFT - 1))) >> SHIFT;
        r  = v[VAL_W-1] ? -val_t'(m) : val_t'(m);
        if (r > OUT_MAX_V)
            r = OUT_MAX_V;
        if (r < OUT_MIN_V)
            r = OUT_MIN_V;
        return out_t'(r[OUT_W-1:0]);
    endfunction

endpackage

[rtl/core/ecu_prep.sv]
// Stage A: operand selection, bounce segment, sine phase and exponent argument.
module ecu_prep (
    input  ecu_pkg::s1_t s1,
    output ecu_pkg::s2_t s2
);
    import ecu_pkg::*;

    val_t             t;
    val_t             u;
    val_t             tb;
    val_t             tb11;
    val_t             ub;
    val_t             n_el;
    val_t             ph_v;
    val_t             ea_v;
    logic             lo;
    logic [MAG_W-1:0] m_el;
    logic [MAG_W-1:0] x3;
    logic [63:0]      prod3;
    logic [63:0]      el_full;

    always_comb
    begin
        t  = s1.t;
        u  = t - IONE;
        lo = t < HALF;

        tb   = (s1.op == OP_BOUNCE_IN) ? IONE - t : t;
        tb11 = tb * val_t'(11);
        if (tb11 < (IONE <<< 2))
        begin
            ub    = tb;
            s2.kb = '0;
        end
        else if (tb11 < (IONE <<< 3))
        begin
            ub    = tb - BOUNCE_C1;
            s2.kb = K_0750;
        end
        else if (tb11 < IONE * val_t'(10))
        begin
            ub    = tb - BOUNCE_C2;
            s2.kb = K_0938;
        end
        else
        begin
            ub    = tb - BOUNCE_C3;
            s2.kb = K_0984;
        end

        // elastic phase: (10t - ofs + 12) / 3 turns, numerator is a multiple of 2^SHIFT
        n_el = t * val_t'(10) - ((s1.op == OP_ELASTIC_IN) ? EL_IN_OFS : K_0750)
             + IONE * val_t'(12);
        m_el    = MAG_W'(n_el >>> SHIFT);
        x3      = m_el * MAG_W'(DIV3_R);
        prod3   = 64'(x3) * 64'(RECIP3);
        el_full = 64'(m_el) * 64'(DIV3_Q) + (prod3 >> RECIP3_SH);

        case (s1.op) inside
            OP_SINE_IN:                    ph_v = (t >>> 2) + (IONE >>> 2);
            OP_SINE_OUT:                   ph_v = t >>> 2;
            OP_SINE_INOUT:                 ph_v = (t >>> 1) + (IONE >>> 2);
            OP_ELASTIC_IN, OP_ELASTIC_OUT: ph_v = val_t'(el_full[IB-1:0]);
            default:                       ph_v = '0;
        endcase

        case (s1.op) inside
            OP_EXPO_IN, OP_ELASTIC_IN:   ea_v = (IONE - t) * val_t'(10);
            OP_EXPO_OUT, OP_ELASTIC_OUT: ea_v = t * val_t'(10);
            OP_EXPO_INOUT:
                ea_v = lo ? IONE * val_t'(10) - t * val_t'(20)
                          : t * val_t'(20) - IONE * val_t'(10);
            default:                     ea_v = '0;
        endcase

        s2.x1 = '0;
        s2.y1 = '0;
        s2.z  = '0;
        s2.y2 = '0;
        case (s1.op) inside
            OP_QUAD_IN:
            begin
                s2.x1 = t;
                s2.y1 = t;
            end
            OP_QUAD_OUT:
            begin
                s2.x1 = t;
                s2.y1 = (IONE <<< 1) - t;
            end
            OP_QUAD_INOUT:
            begin
                s2.x1 = lo ? t : (IONE <<< 2) - (t <<< 1);
                s2.y1 = t;
            end
            OP_CUBIC_IN:
            begin
                s2.x1 = t;
                s2.y1 = t;
                s2.y2 = t;
            end
            OP_CUBIC_OUT:
            begin
                s2.x1 = u;
                s2.y1 = u;
                s2.y2 = u;
            end
            OP_CUBIC_INOUT:
            begin
                s2.x1 = lo ? t : u;
                s2.y1 = lo ? t : u;
                s2.y2 = lo ? t : u;
            end
            OP_BOUNCE_OUT, OP_BOUNCE_IN:
            begin
                s2.x1 = ub;
                s2.y1 = ub;
                s2.y2 = BOUNCE_K;
            end
            OP_BACK_IN:
            begin
                s2.x1 = t;
                s2.y1 = t;
                s2.z  = t;
            end
            OP_BACK_OUT:
            begin
                s2.x1 = u;
                s2.y1 = u;
                s2.z  = u;
            end
            default:
            begin
                s2.x1 = '0;
            end
        endcase

        s2.op      = s1.op;
        s2.t       = t;
        s2.lo      = lo;
        s2.phase   = ph_v[IB-1:0];
        s2.exp_arg = ea_v[EXP_ARG_W-1:0];
    end

endmodule

[rtl/core/ecu_lookup.sv]
// Stage B: first product, back slope term, and sine / octave table reads.
module ecu_lookup (
    input  ecu_pkg::s2_t s2,
    output ecu_pkg::s3_t s3
);
    import ecu_pkg::*;

    localparam int SPOS_W = QB + 1 + SIDX_W;
    localparam int EPOS_W = IB + EIDX_W;

    val_t              w;
    logic              back;
    logic [1:0]        quad;
    logic [QB:0]       r;
    logic [SPOS_W-1:0] s_pos;
    logic [SIDX_W-1:0] s_idx;
    logic [SIDX_W-1:0] s_idx_b;
    logic              s_sat;
    rom_word_t         sa;
    rom_word_t         sb;
    logic [EPOS_W-1:0] e_pos;
    logic [EIDX_W-1:0] e_idx;
    rom_word_t         ea;
    rom_word_t         eb;

    always_comb
    begin
        back = (s2.op == OP_BACK_IN) || (s2.op == OP_BACK_OUT);
        w    = smul(BACK_S1, s2.z) + ((s2.op == OP_BACK_IN) ? -BACK_S : BACK_S);

        // quarter-wave fold
        quad = s2.phase[IB-1:QB];
        r    = {1'b0, s2.phase[QB-1:0]};
        if (quad[0])
            r = ((QB+1)'(1) << QB) - r;
        s_pos   = SPOS_W'(r) * SPOS_W'(SINE_TABLE_DEPTH);
        s_idx   = s_pos[QB +: SIDX_W];
        s_sat   = s_idx >= SIDX_W'(SINE_TABLE_DEPTH);
        s_idx_b = s_sat ? s_idx : s_idx + SIDX_W'(1);
        sa      = SINE_ROM[s_idx];
        sb      = SINE_ROM[s_idx_b];
        if (sb < sa)
            sb = sa;

        e_pos = EPOS_W'(s2.exp_arg[IB-1:0]) * EPOS_W'(EXP_TABLE_DEPTH);
        e_idx = e_pos[IB +: EIDX_W];
        ea    = EXP_ROM[e_idx];
        eb    = EXP_ROM[e_idx + EIDX_W'(1)];
        if (eb > ea)
            eb = ea;

        s3.op    = s2.op;
        s3.t     = s2.t;
        s3.lo    = s2.lo;
        s3.kb    = s2.kb;
        s3.m1    = smul(s2.x1, s2.y1);
        s3.y2    = back ? w : s2.y2;
        s3.s_a   = sa;
        s3.s_d   = sb - sa;
        s3.s_fr  = s_pos[QB-1:0];
        s3.s_neg = quad[1];
        s3.e_a   = ea;
        s3.e_d   = ea - eb;
        s3.e_fr  = e_pos[IB-1:0];
        s3.e_n   = s2.exp_arg[EXP_ARG_W-1:IB];
    end

endmodule

[rtl/core/ecu_interp.sv]
// Stage C: second product and linear interpolation of both tables.
module ecu_interp (
    input  ecu_pkg::s3_t s3,
    output ecu_pkg::s4_t s4
);
    import ecu_pkg::*;

    localparam int SP_W = ROM_W + QB;
    localparam int EP_W = ROM_W + IB;

    logic [SP_W-1:0] s_prod;
    logic [EP_W-1:0] e_prod;
    rom_word_t       s_mag;
    rom_word_t       e_val;

    always_comb
    begin
        s_prod = SP_W'(s3.s_d) * SP_W'(s3.s_fr);
        s_mag  = s3.s_a + ROM_W'((s_prod + (SP_W'(1) << (QB - 1))) >> QB);
        e_prod = EP_W'(s3.e_d) * EP_W'(s3.e_fr);
        e_val  = s3.e_a - ROM_W'((e_prod + (EP_W'(1) << (IB - 1))) >> IB);

        s4.op = s3.op;
        s4.t  = s3.t;
        s4.lo = s3.lo;
        s4.kb = s3.kb;
        s4.m1 = s3.m1;
        s4.m2 = smul(s3.m1, s3.y2);
        s4.sv = s3.s_neg ? -val_t'(s_mag) : val_t'(s_mag);
        s4.ev = val_t'(e_val >> s3.e_n);
    end

endmodule

[rtl/core/ecu_blend.sv]
// Stage D: per-curve combination, endpoint cases and the elastic product.
module ecu_blend (
    input  ecu_pkg::s4_t s4,
    output ecu_pkg::val_t v
);
    import ecu_pkg::*;

    val_t el;
    logic zero;
    logic one;

    always_comb
    begin
        el   = smul(s4.ev, s4.sv);
        zero = s4.t == '0;
        one  = s4.t == IONE;
        case (s4.op) inside
            OP_LINEAR:                 v = s4.t;
            OP_QUAD_IN, OP_QUAD_OUT:   v = s4.m1;
            OP_QUAD_INOUT:             v = s4.lo ? (s4.m1 <<< 1) : s4.m1 - IONE;
            OP_CUBIC_IN, OP_BACK_IN:   v = s4.m2;
            OP_CUBIC_OUT, OP_BACK_OUT: v = s4.m2 + IONE;
            OP_CUBIC_INOUT:            v = (s4.m2 <<< 2) + (s4.lo ? val_t'(0) : IONE);
            OP_SINE_IN:                v = IONE - s4.sv;
            OP_SINE_OUT:               v = s4.sv;
            OP_SINE_INOUT:             v = (IONE - s4.sv) >>> 1;
            OP_EXPO_IN:                v = zero ? val_t'(0) : s4.ev;
            OP_EXPO_OUT:               v = one ? IONE : IONE - s4.ev;
            OP_EXPO_INOUT:
            begin
                if (zero)
                    v = '0;
                else if (one)
                    v = IONE;
                else
                    v = s4.lo ? (s4.ev >>> 1) : IONE - (s4.ev >>> 1);
            end
            OP_ELASTIC_IN:             v = (zero || one) ? s4.t : -el;
            OP_ELASTIC_OUT:            v = (zero || one) ? s4.t : el + IONE;
            OP_BOUNCE_OUT:             v = s4.m2 + s4.kb;
            OP_BOUNCE_IN:              v = IONE - (s4.m2 + s4.kb);
            default:                   v = '0;
        endcase
    end

endmodule

[rtl/core/easing_curve_unit.sv]
// An accepted input beat passes through the s1, s2, s3, s4, v and eased_value registers to the output.
// Throughput: one beat per cycle while the output is not stalled; six register stages, each
// holding at most one multiplier deep of logic, with per-stage valid bits so bubbles are squeezed out.
// A stalled output holds only the stages that are full behind it.
// Reset clears the valid bits; payload registers are not reset.
`include "assert_macros.svh"

module easing_curve_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [ecu_pkg::OP_W-1:0]     opcode,
    input  logic [ecu_pkg::PROG_W-1:0]   progress,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [ecu_pkg::OUT_W-1:0] eased_value
);
    import ecu_pkg::*;

    localparam int NSTG = 6;

    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] en;

    s1_t  s1_reg;
    s1_t  s1_next;
    s2_t  s2_reg;
    s2_t  s2_next;
    s3_t  s3_reg;
    s3_t  s3_next;
    s4_t  s4_reg;
    s4_t  s4_next;
    val_t v_reg;
    val_t v_next;
    out_t eased_value_reg;
    out_t eased_value_next;

    logic [31:0] p_sat;

    // a stage may load when it is empty or the stage ahead is loading
    always_comb
    begin
        en[NSTG-1] = !valid_reg[NSTG-1] || !out_stall;
        for (int k = NSTG - 2; k >= 0; k--)
            en[k] = !valid_reg[k] || en[k+1];
    end

    assign in_stall = !en[0];

    always_comb
    begin
        p_sat = 32'(progress);
        if (p_sat > (32'd1 << FRAC_BITS))
            p_sat = 32'd1 << FRAC_BITS;
        s1_next.op = op_t'(opcode);
        s1_next.t  = val_t'(p_sat) <<< SHIFT;
    end

    ecu_prep   u_prep   (.s1(s1_reg), .s2(s2_next));
    ecu_lookup u_lookup (.s2(s2_reg), .s3(s3_next));
    ecu_interp u_interp (.s3(s3_reg), .s4(s4_next));
    ecu_blend  u_blend  (.s4(s4_reg), .v(v_next));

    assign eased_value_next = round_out(v_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
                valid_reg[0] <= in_valid;
            for (int k = 1; k < NSTG; k++)
            begin
                if (en[k])
                    valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
            s1_reg <= s1_next;
        if (en[1])
            s2_reg <= s2_next;
        if (en[2])
            s3_reg <= s3_next;
        if (en[3])
            s4_reg <= s4_next;
        if (en[4])
            v_reg <= v_next;
        if (en[5])
            eased_value_reg <= eased_value_next;
    end

    assign out_valid   = valid_reg[NSTG-1];
    assign eased_value = eased_value_reg;

    `ECU_ASSERT(a_stall_needs_full_pipe, in_stall |-> (out_valid && out_stall), "input stalled while output free")
    `ECU_ASSERT(a_stage_advances, (valid_reg[0] && en[1]) |=> valid_reg[1], "beat lost between first stages")
    `ECU_ASSERT(a_output_drains, (out_valid && !out_stall && !valid_reg[NSTG-2]) |=> !out_valid, "beat repeated on output")
    `ECU_NEVER(a_no_stall_when_empty, in_stall && !valid_reg[0], "stall with empty input stage")

endmodule
